// ----- rtl/md4c_pkg.sv -----
// md4c_pkg: shared types, constants and schedule functions for the md4 compression core
// no dependencies; imported by every module of the block
`default_nettype none

package md4c_pkg;

    localparam logic [31:0] IV_A = 32'h6745_2301;
    localparam logic [31:0] IV_B = 32'hefcd_ab89;
    localparam logic [31:0] IV_C = 32'h98ba_dcfe;
    localparam logic [31:0] IV_D = 32'h1032_5476;

    localparam logic [31:0] K_ROUND1 = 32'h0000_0000;
    localparam logic [31:0] K_ROUND2 = 32'h5a82_7999;
    localparam logic [31:0] K_ROUND3 = 32'h6ed9_eba1;

    localparam int unsigned WORDS_PER_BLOCK = 16;
    localparam int unsigned STEPS_PER_BLOCK = 48;

    localparam logic [1:0] ROUND_F = 2'd0;
    localparam logic [1:0] ROUND_G = 2'd1;
    localparam logic [1:0] ROUND_H = 2'd2;

    typedef logic [$clog2(WORDS_PER_BLOCK)-1:0] word_idx_t;
    typedef logic [$clog2(STEPS_PER_BLOCK)-1:0] step_idx_t;

    typedef struct packed {
        logic [31:0] message_word;
        logic        restart;
    } msg_word_t;

    typedef struct packed {
        logic [31:0] hash_a;
        logic [31:0] hash_b;
        logic [31:0] hash_c;
        logic [31:0] hash_d;
    } hash_word_t;

    typedef struct packed {
        logic [1:0] round;
        logic [4:0] shamt;
        logic [31:0] k;
    } step_ctl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PREP,
        ST_ROUND,
        ST_FINAL
    } state_t;

    function automatic word_idx_t word_sel(input step_idx_t step);
        word_idx_t j;
        word_idx_t sel;
        j = step[3:0];
        case (step[5:4])
            ROUND_G: sel = {j[1:0], j[3:2]};
            ROUND_H: sel = {j[0], j[1], j[2], j[3]};
            default: sel = j;
        endcase
        return sel;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [1:0] round, input logic [1:0] pos);
        logic [4:0] s;
        case ({round, pos})
            {ROUND_F, 2'd0}: s = 5'd3;
            {ROUND_F, 2'd1}: s = 5'd7;
            {ROUND_F, 2'd2}: s = 5'd11;
            {ROUND_F, 2'd3}: s = 5'd19;
            {ROUND_G, 2'd0}: s = 5'd3;
            {ROUND_G, 2'd1}: s = 5'd5;
            {ROUND_G, 2'd2}: s = 5'd9;
            {ROUND_G, 2'd3}: s = 5'd13;
            {ROUND_H, 2'd0}: s = 5'd3;
            {ROUND_H, 2'd1}: s = 5'd9;
            {ROUND_H, 2'd2}: s = 5'd11;
            {ROUND_H, 2'd3}: s = 5'd15;
            default:         s = 5'd3;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] round_add(input logic [1:0] round);
        logic [31:0] k;
        case (round)
            ROUND_G: k = K_ROUND2;
            ROUND_H: k = K_ROUND3;
            default: k = K_ROUND1;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/md4c_step.sv -----
// md4c_step: one md4 step, a = rotl(a + f(b,c,d) + x + k, s)
// depends on md4c_pkg for the step control struct and round codes
`default_nettype none

module md4c_step
    import md4c_pkg::*;
(
    input  wire step_ctl_t   ctl,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire logic [31:0] c,
    input  wire logic [31:0] d,
    input  wire logic [31:0] x,
    output logic [31:0]      result
);

    logic [31:0] mix;
    logic [31:0] sum;
    logic [5:0]  back;

    always_comb
    begin
        case (ctl.round)
            ROUND_F: mix = (b & c) | (~b & d);
            ROUND_G: mix = (b & c) | (b & d) | (c & d);
            default: mix = b ^ c ^ d;
        endcase
    end

    assign sum     = a + mix + x + ctl.k;
    assign back    = 6'd32 - {1'b0, ctl.shamt};
    // rotate left by shamt, shamt never zero
    assign result  = (sum << ctl.shamt) | (sum >> back);

endmodule

`default_nettype wire

// ----- rtl/md4_block_compression_core.sv -----
// md4_block_compression_core: md4 block compression, one message word per handshake
// depends on md4c_pkg and md4c_step
//
//  channel | dir | handshake          | word
//  msg     | in  | msg_valid/msg_stall | msg_word_t  (message_word, restart)
//  hash    | out | hash_valid/hash_stall | hash_word_t (hash_a .. hash_d)
//
// words 0 to 14 of a block are taken one per cycle
// word 15 starts compression: a prep state, 48 steps on the shared step unit, then a final add
// msg_stall is high through the prep, step and final states of each 16-word block
// a hash still held at the final add keeps the core there and msg_stall high until it is taken
// reset loads the md4 initial chaining value and clears the word count
`default_nettype none

module md4_block_compression_core
    import md4c_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       msg_valid,
    output logic            msg_stall,
    input  wire msg_word_t  msg,
    output logic            hash_valid,
    input  wire logic       hash_stall,
    output hash_word_t      hash
);

    state_t      state_reg, state_next;
    word_idx_t   word_count_reg, word_count_next;
    step_idx_t   step_reg, step_next;
    logic [31:0] chain_a_reg, chain_b_reg, chain_c_reg, chain_d_reg;
    logic [31:0] chain_a_next, chain_b_next, chain_c_next, chain_d_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic        hash_valid_reg, hash_valid_next;
    hash_word_t  hash_reg, hash_next;
    logic [31:0] rd_data_reg;
    logic [31:0] block_mem [WORDS_PER_BLOCK];

    logic        msg_accept;
    word_idx_t   wr_idx;
    word_idx_t   rd_addr;
    step_ctl_t   ctl;
    logic [31:0] step_result;

    assign msg_stall  = (state_reg != ST_LOAD);
    assign msg_accept = msg_valid && !msg_stall;
    assign wr_idx     = msg.restart ? '0 : word_count_reg;
    assign hash_valid = hash_valid_reg;
    assign hash       = hash_reg;

    assign ctl.round = step_reg[5:4];
    assign ctl.shamt = rot_amt(step_reg[5:4], step_reg[1:0]);
    assign ctl.k     = round_add(step_reg[5:4]);

    md4c_step u_step (
        .ctl    (ctl),
        .a      (a_reg),
        .b      (b_reg),
        .c      (c_reg),
        .d      (d_reg),
        .x      (rd_data_reg),
        .result (step_result)
    );

    always_comb
    begin
        state_next      = state_reg;
        word_count_next = word_count_reg;
        step_next       = step_reg;
        chain_a_next    = chain_a_reg;
        chain_b_next    = chain_b_reg;
        chain_c_next    = chain_c_reg;
        chain_d_next    = chain_d_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        d_next          = d_reg;
        hash_next       = hash_reg;
        hash_valid_next = hash_valid_reg && hash_stall;
        rd_addr         = word_sel('0);

        case (state_reg)
            ST_LOAD:
            begin
                if (msg_accept)
                begin
                    if (msg.restart)
                    begin
                        chain_a_next = IV_A;
                        chain_b_next = IV_B;
                        chain_c_next = IV_C;
                        chain_d_next = IV_D;
                    end
                    word_count_next = wr_idx + 1'b1;
                    if (&wr_idx)
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                rd_addr    = word_sel('0);
                a_next     = chain_a_reg;
                b_next     = chain_b_reg;
                c_next     = chain_c_reg;
                d_next     = chain_d_reg;
                step_next  = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                rd_addr   = word_sel(step_reg + 1'b1);
                a_next    = d_reg;
                b_next    = step_result;
                c_next    = b_reg;
                d_next    = c_reg;
                step_next = step_reg + 1'b1;
                if (step_reg == step_idx_t'(STEPS_PER_BLOCK - 1))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (!hash_valid_reg || !hash_stall)
                begin
                    chain_a_next     = chain_a_reg + a_reg;
                    chain_b_next     = chain_b_reg + b_reg;
                    chain_c_next     = chain_c_reg + c_reg;
                    chain_d_next     = chain_d_reg + d_reg;
                    hash_next.hash_a = chain_a_next;
                    hash_next.hash_b = chain_b_next;
                    hash_next.hash_c = chain_c_next;
                    hash_next.hash_d = chain_d_next;
                    hash_valid_next  = 1'b1;
                    state_next       = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            word_count_reg <= '0;
            step_reg       <= '0;
            chain_a_reg    <= IV_A;
            chain_b_reg    <= IV_B;
            chain_c_reg    <= IV_C;
            chain_d_reg    <= IV_D;
            hash_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            word_count_reg <= word_count_next;
            step_reg       <= step_next;
            chain_a_reg    <= chain_a_next;
            chain_b_reg    <= chain_b_next;
            chain_c_reg    <= chain_c_next;
            chain_d_reg    <= chain_d_next;
            hash_valid_reg <= hash_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        hash_reg <= hash_next;
    end

    // block word buffer, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (msg_accept)
        begin
            block_mem[wr_idx] <= msg.message_word;
        end
        rd_data_reg <= block_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/md4c_checker.sv -----
// md4c_checker: port-level checks on the md4 compression core over time
// depends on md4c_pkg; bound to md4_block_compression_core
`default_nettype none

module md4c_checker
    import md4c_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       msg_valid,
    input wire logic       msg_stall,
    input wire logic       hash_valid,
    input wire logic       hash_stall,
    input wire hash_word_t hash
);

    // held hash stays put
    a_hash_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hash_valid && hash_stall |=> hash_valid && $stable(hash))
        else $error("hash changed while stalled");

    // a new hash only appears at the end of a busy stretch
    a_hash_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hash_valid) |-> $past(msg_stall))
        else $error("hash appeared while taking words");

    // busy only starts after a word was offered
    a_busy_after_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(msg_stall) |-> $past(msg_valid))
        else $error("stall rose without a word");

    // stall stays high in the cycle after it rises
    a_busy_lasts: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(msg_stall) |=> msg_stall)
        else $error("stall dropped too early");

endmodule

bind md4_block_compression_core md4c_checker u_md4c_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .msg_valid  (msg_valid),
    .msg_stall  (msg_stall),
    .hash_valid (hash_valid),
    .hash_stall (hash_stall),
    .hash       (hash)
);

`default_nettype wire
